// File: design/terrain_cell_blend_mesh_setup_core_macros.svh
// ----------------------------------------------------------------------------
// Terrain cell blend setup - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TERRAIN_CELL_BLEND_MESH_SETUP_CORE_MACROS_SVH
`define TERRAIN_CELL_BLEND_MESH_SETUP_CORE_MACROS_SVH

// same-cycle implication
`define TCBMS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcbms: same-cycle check failed");

// next-cycle implication
`define TCBMS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcbms: next-cycle check failed");

`endif

// File: design/tcbms_pkg.sv
// ----------------------------------------------------------------------------
// Terrain cell blend setup - package
// Types, constants and pattern functions shared by the core and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package tcbms_pkg;

  localparam int NUM_CORNERS = 4;
  localparam int NUM_LAYERS  = 5;
  localparam int NUM_VERTS   = 6;
  localparam int NUM_BEATS   = NUM_VERTS * NUM_LAYERS;

  localparam logic [5:0] ROAD_TEXTURE   = 6'h20;
  localparam logic [2:0] ROAD_LAYER     = 3'd4;
  localparam logic [2:0] LAST_VERT      = 3'(NUM_VERTS - 1);
  localparam logic [7:0] NO_PATTERN     = 8'hFF;
  localparam logic [3:0] ROAD_DIAG_MASK = 4'h5;

  typedef logic [3:0] mask_t;
  typedef logic [4:0] terr_t;

  typedef struct packed {
    logic [7:0]      cx;
    logic [7:0]      cy;
    logic [3:0][7:0] hgt;
    logic            split;
  } cell_t;

  typedef struct packed {
    logic [7:0] code;
    logic [1:0] rot;
    mask_t      mask;
  } class_t;

  typedef struct packed {
    logic [5:0] tex;
    logic [7:0] blend;
    logic [1:0] rot;
  } layer_t;

  function automatic mask_t rotl4(mask_t m);
    return {m[2:0], m[3]};
  endfunction

  function automatic logic [7:0] terrain_pattern(mask_t m);
    logic [7:0] c;
    unique case (m)
      4'h1:    c = 8'h08;
      4'h9:    c = 8'h02;
      4'h5:    c = 8'h00;
      4'hE:    c = 8'h88;
      4'hF:    c = 8'h01;
      default: c = NO_PATTERN;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] road_pattern(mask_t m);
    logic [7:0] c;
    unique case (m)
      4'h0:    c = 8'h00;
      4'h1:    c = 8'h05;
      4'h9:    c = 8'h02;
      4'h5:    c = 8'h0A;
      4'hE:    c = 8'h85;
      4'hF:    c = 8'h01;
      default: c = NO_PATTERN;
    endcase
    return c;
  endfunction

  // first rotation (0..3) that hits a pattern; mask is the matched form
  function automatic class_t classify(mask_t m, logic road);
    class_t     c;
    mask_t      cur;
    logic [7:0] code;
    c.code = NO_PATTERN;
    c.rot  = 2'd0;
    c.mask = m;
    cur    = m;
    for (int k = 0; k < 4; k++) begin
      code = road ? road_pattern(cur) : terrain_pattern(cur);
      if (c.code == NO_PATTERN && code != NO_PATTERN) begin
        c.code = code;
        c.rot  = 2'(k);
        c.mask = cur;
      end
      cur = rotl4(cur);
    end
    return c;
  endfunction

  // {dx, dy} of vertex v for the chosen diagonal
  function automatic logic [1:0] vertex_corner(logic split, logic [2:0] v);
    logic [1:0] d;
    if (split) begin
      unique case (v)
        3'd0:    d = 2'b00;
        3'd1:    d = 2'b10;
        3'd2:    d = 2'b11;
        3'd3:    d = 2'b11;
        3'd4:    d = 2'b01;
        default: d = 2'b00;
      endcase
    end else begin
      unique case (v)
        3'd0:    d = 2'b00;
        3'd1:    d = 2'b10;
        3'd2:    d = 2'b01;
        3'd3:    d = 2'b10;
        3'd4:    d = 2'b11;
        default: d = 2'b01;
      endcase
    end
    return d;
  endfunction

  // quarter turns counter-clockwise about the cell center, returns {s, t}
  function automatic logic [1:0] rotate_corner(logic s, logic t, logic [1:0] r);
    logic [1:0] st;
    unique case (r)
      2'd0:    st = {s, t};
      2'd1:    st = {~t, s};
      2'd2:    st = {~s, ~t};
      default: st = {t, ~s};
    endcase
    return st;
  endfunction

endpackage

`default_nettype wire

// File: design/terrain_cell_blend_mesh_setup_core.sv
// ----------------------------------------------------------------------------
// Terrain cell blend setup core
// Classifies the terrain and road blend layers of one grid cell and emits
// its two triangles as six vertices of five layer beats each.
// ----------------------------------------------------------------------------
// Each accepted cell produces 30 output beats, one per cycle while out_ready
// is high, and cells stream back to back, the next cell's first beat
// following the last beat of the one before. The beat sequencer feeding the
// output register paces the beats. A cell passes an input register, a
// corner-mask stage and a pattern-classification stage before the sequencer;
// its beats then leave through the output register, and up to three further
// cells wait in the stages while one is being emitted.
`default_nettype none

module terrain_cell_blend_mesh_setup_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] cell_x,
  input  wire logic [7:0] cell_y,
  input  wire logic [15:0] style_ll,
  input  wire logic [15:0] style_lr,
  input  wire logic [15:0] style_ur,
  input  wire logic [15:0] style_ul,
  input  wire logic [7:0] height_ll,
  input  wire logic [7:0] height_lr,
  input  wire logic [7:0] height_ur,
  input  wire logic [7:0] height_ul,
  input  wire logic       split_diagonal,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      vertex_x,
  output logic [7:0]      vertex_y,
  output logic [7:0]      vertex_height,
  output logic            corner_dx,
  output logic            corner_dy,
  output logic [2:0]      layer_index,
  output logic [1:0]      tex_s,
  output logic [1:0]      tex_t,
  output logic [7:0]      blend_code,
  output logic [5:0]      texture_id,
  output logic            last
);

  import tcbms_pkg::*;

  // stage 1: captured cell
  logic                   s1_valid;
  cell_t                  s1_cell;
  terr_t [3:0]            s1_terr;
  mask_t                  s1_road;
  // stage 2: corner masks
  logic                   s2_valid;
  cell_t                  s2_cell;
  terr_t [3:0]            s2_terr;
  mask_t [3:0]            s2_mask;
  mask_t                  s2_road;
  mask_t [3:0]            mask_next;
  // stage 3: classified layers
  logic                   s3_valid;
  cell_t                  s3_cell;
  layer_t                 s3_layer [NUM_LAYERS];
  logic                   s3_scale3;
  layer_t                 layer_next [NUM_LAYERS];
  logic                   scale3_next;
  class_t                 cls [NUM_CORNERS];
  class_t                 road_cls;
  logic [3:0]             first;
  logic [2:0]             cnt;
  // sequencer
  logic                   e_valid;
  cell_t                  e_cell;
  layer_t                 e_layer [NUM_LAYERS];
  logic                   e_scale3;
  logic [2:0]             e_vert;
  logic [2:0]             e_lyr;

  logic s2_ready, s3_ready, e_ready, advance, final_beat, load;
  logic dx, dy, scale3;
  logic [1:0] corner, st;
  layer_t cur;

  assign s3_ready = !s3_valid || e_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign in_ready = !s1_valid || s2_ready;

  // ---- stage 1 ----
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cell.cx    <= cell_x;
      s1_cell.cy    <= cell_y;
      s1_cell.hgt   <= {height_ul, height_ur, height_lr, height_ll};
      s1_cell.split <= split_diagonal;
      s1_terr       <= {style_ul[6:2], style_ur[6:2], style_lr[6:2], style_ll[6:2]};
      s1_road       <= {|style_ul[1:0], |style_ur[1:0], |style_lr[1:0], |style_ll[1:0]};
    end
  end

  // ---- stage 2 ----
  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      for (int j = 0; j < NUM_CORNERS; j++) begin
        mask_next[i][j] = (s1_terr[j] == s1_terr[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_cell <= s1_cell;
      s2_terr <= s1_terr;
      s2_mask <= mask_next;
      s2_road <= s1_road;
    end
  end

  // ---- stage 3 ----
  always_comb begin
    cnt = 3'd0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      first[i] = 1'b1;
      for (int j = 0; j < i; j++) begin
        if (s2_mask[i][j]) begin
          first[i] = 1'b0;
        end
      end
      cls[i] = classify(s2_mask[i], 1'b0);
    end
    for (int l = 0; l < NUM_LAYERS; l++) begin
      layer_next[l] = '0;
    end
    for (int i = 0; i < NUM_CORNERS; i++) begin
      if (first[i]) begin
        layer_next[cnt[1:0]] = '{tex: {1'b0, s2_terr[i]}, blend: cls[i].code,
                                 rot: cls[i].rot};
        cnt = cnt + 3'd1;
      end
    end
    road_cls = classify(s2_road, 1'b1);
    layer_next[ROAD_LAYER] = '{tex: ROAD_TEXTURE, blend: road_cls.code,
                               rot: road_cls.rot};
    scale3_next = (road_cls.mask != ROAD_DIAG_MASK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s3_ready) begin
      s3_cell   <= s2_cell;
      s3_layer  <= layer_next;
      s3_scale3 <= scale3_next;
    end
  end

  // ---- beat sequencer ----
  assign advance    = e_valid && (!out_valid || out_ready);
  assign final_beat = (e_vert == LAST_VERT) && (e_lyr == ROAD_LAYER);
  assign e_ready    = !e_valid || (advance && final_beat);
  assign load       = s3_valid && e_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      e_vert  <= 3'd0;
      e_lyr   <= 3'd0;
    end else if (load) begin
      e_valid <= 1'b1;
      e_vert  <= 3'd0;
      e_lyr   <= 3'd0;
    end else if (advance) begin
      if (e_lyr == ROAD_LAYER) begin
        e_lyr  <= 3'd0;
        e_vert <= e_vert + 3'd1;
      end else begin
        e_lyr <= e_lyr + 3'd1;
      end
      if (final_beat) begin
        e_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      e_cell   <= s3_cell;
      e_layer  <= s3_layer;
      e_scale3 <= s3_scale3;
    end
  end

  assign {dx, dy} = vertex_corner(e_cell.split, e_vert);
  assign corner   = dy ? (dx ? 2'd2 : 2'd3) : (dx ? 2'd1 : 2'd0);
  assign cur      = e_layer[e_lyr];
  assign st       = rotate_corner(dx, dy, cur.rot);
  assign scale3   = (e_lyr == ROAD_LAYER) && e_scale3;

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      vertex_x      <= e_cell.cx + {7'd0, dx};
      vertex_y      <= e_cell.cy + {7'd0, dy};
      vertex_height <= e_cell.hgt[corner];
      corner_dx     <= dx;
      corner_dy     <= dy;
      layer_index   <= e_lyr;
      tex_s         <= scale3 ? {st[1], st[1]} : {1'b0, st[1]};
      tex_t         <= scale3 ? {st[0], st[0]} : {1'b0, st[0]};
      blend_code    <= cur.blend;
      texture_id    <= cur.tex;
      last          <= final_beat;
    end
  end

endmodule

`default_nettype wire

// File: design/tcbms_checker.sv
// ----------------------------------------------------------------------------
// Terrain cell blend setup - port checker
// Watches the output beats of the core and their grouping into cells.
// ----------------------------------------------------------------------------
`default_nettype none

`include "terrain_cell_blend_mesh_setup_core_macros.svh"

module tcbms_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] vertex_x,
  input wire logic [7:0] blend_code,
  input wire logic [2:0] layer_index,
  input wire logic [5:0] texture_id,
  input wire logic       last
);

  import tcbms_pkg::*;

  localparam int BEAT_W = $clog2(NUM_BEATS);

  logic [BEAT_W-1:0] beat;
  logic [2:0]        exp_layer;
  logic              out_fire;

  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat      <= '0;
      exp_layer <= 3'd0;
    end else if (out_fire) begin
      beat      <= (beat == BEAT_W'(NUM_BEATS - 1)) ? '0 : beat + 1'b1;
      exp_layer <= (exp_layer == ROAD_LAYER) ? 3'd0 : exp_layer + 3'd1;
    end
  end

  `TCBMS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(vertex_x) && $stable(blend_code) && $stable(last))
  `TCBMS_ASSERT_IMP(a_layer_order, out_fire, layer_index == exp_layer)
  `TCBMS_ASSERT_IMP(a_last_beat, out_fire, last == (beat == BEAT_W'(NUM_BEATS - 1)))
  `TCBMS_ASSERT_IMP(a_road_tex, out_fire && layer_index == ROAD_LAYER, texture_id == ROAD_TEXTURE)

endmodule

bind terrain_cell_blend_mesh_setup_core tcbms_checker u_tcbms_checker (.*);

`default_nettype wire
